### hdl/bss_pkg.sv
// Shared types, command codes and constants of the beat scene sequencer.
`default_nettype none

package bss_pkg;

  // Default number of scenes in the rotation
  localparam int SceneCountDefault = 6;

  // Frame commands
  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_NEXT   = 2'd1;
  localparam logic [1:0] CMD_FREEZE = 2'd2;

  // Register indexes (word address bit 2 of the APB port)
  localparam logic REG_AREA_WIDTH  = 1'b0;
  localparam logic REG_AREA_HEIGHT = 1'b1;

  localparam logic [9:0] AREA_WIDTH_RESET  = 10'd320;
  localparam logic [9:0] AREA_HEIGHT_RESET = 10'd200;

  // Area limits
  localparam logic [9:0] MIN_WIDTH       = 10'd80;
  localparam logic [9:0] MIN_HEIGHT      = 10'd60;
  localparam logic [9:0] HEIGHT_MARGIN_AT = 10'd24;
  localparam logic [9:0] HEIGHT_MARGIN   = 10'd18;

  // Beat and scene thresholds
  localparam logic [7:0]  BEAT_THRESHOLD   = 8'd68;
  localparam logic [7:0]  STRONG_ONSET     = 8'd80;
  localparam logic [15:0] OLD_SCENE_AGE    = 16'd420;
  localparam logic [7:0]  DROP_ONSET       = 8'd55;
  localparam logic [15:0] DROP_MIN_AGE     = 16'd75;
  localparam logic [2:0]  DARK_DROP_SCENE  = 3'd5;
  localparam logic [2:0]  BLANK_FRAMES     = 3'd5;
  localparam logic [7:0]  BURST_ON_CHANGE  = 8'd100;

  // floor(x * 72 / 100) = (x * 47186) >> 16 for any 8-bit x
  localparam logic [23:0] DECAY_RECIP = 24'd47186;
  // floor(x / 3) = (x * 683) >> 11 for x up to 765
  localparam logic [19:0] THIRD_RECIP = 20'd683;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] bass_level;
    logic [7:0] mid_level;
    logic [7:0] treble_level;
    logic [7:0] onset_level;
  } frame_t;

  typedef struct packed {
    logic [2:0]  scene;
    logic        blanking;
    logic [2:0]  blank_left;
    logic        beat_seen;
    logic [15:0] beats;
    logic [15:0] scene_age;
    logic [7:0]  burst_level;
    logic [7:0]  hue_phase;
    logic [7:0]  orbit_phase;
    logic [7:0]  drift_phase;
    logic [7:0]  brush_phase_out;
    logic        is_frozen;
  } result_t;

endpackage

`default_nettype wire

### hdl/beat_scene_sequencer_core.sv
// Beat scene sequencer: per-frame beat detection, scene rotation and phase accumulators.
//
// Usage: one beat on the frame channel per video frame (frame_valid / frame_stall,
// payload frame) carries a command and the bass, mid, treble and onset levels.
// Each beat yields exactly one beat on the result channel (result_valid /
// result_stall, payload result) holding the scene, blanking countdown, beat
// count, scene age, burst level, four phase accumulators and the freeze flag.
// The frame lands in an input register, then one short combinational pass
// updates the scene state and loads the result register. Throughput is one
// frame per cycle while the receiver does not stall; the scene state
// registers feed back directly, so back-to-back frames never wait on each other.
// When the receiver stalls, the result register holds and the input register
// absorbs one more frame before frame_stall rises.
// The APB port sets the drawing area (width at 0x0, height at 0x4); write it
// only while no frame is in flight. Reset (rst, synchronous) clears all scene
// state, empties both registers and restores the area to 320 by 200.
`default_nettype none

module beat_scene_sequencer_core
  import bss_pkg::*;
#(
  parameter int SCENE_COUNT = SceneCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // frame channel
  input  wire logic        frame_valid,
  output logic             frame_stall,
  input  wire frame_t      frame,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [3:0] SceneWrap = 4'(SCENE_COUNT);

  // Configuration registers
  logic [9:0] area_width;
  logic [9:0] area_height;

  // Scene state
  logic [2:0]  scene_reg;
  logic [15:0] age_reg;
  logic [15:0] beat_reg;
  logic [7:0]  burst_reg;
  logic [7:0]  prev_onset;
  logic [2:0]  blank_count;
  logic [7:0]  phase_regs [4];
  logic        freeze_flag;

  logic [2:0]  scene_next;
  logic [15:0] age_next;
  logic [15:0] beat_next;
  logic [7:0]  burst_next;
  logic [7:0]  prev_onset_next;
  logic [2:0]  blank_next;
  logic [7:0]  phase_next [4];
  logic        freeze_next;
  logic        blanking_now;
  logic        beat_now;

  // Input register
  frame_t held;
  logic   held_valid;

  logic advance;
  logic take;
  logic fire;

  logic [9:0]  usable_h;
  logic        area_ok;
  logic [3:0]  scene_inc;
  logic [2:0]  scene_step;
  logic [9:0]  band_sum;
  logic [19:0] third_prod;
  logic [7:0]  energy;

  // APB: always ready, write on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= AREA_WIDTH_RESET;
      area_height <= AREA_HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_AREA_WIDTH:  area_width  <= pwdata[9:0];
        REG_AREA_HEIGHT: area_height <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_AREA_WIDTH:  prdata = {22'd0, area_width};
      REG_AREA_HEIGHT: prdata = {22'd0, area_height};
      default:         prdata = 32'd0;
    endcase
  end

  // Handshake: the result register frees when empty or taken
  assign advance     = !result_valid || !result_stall;
  assign fire        = held_valid && advance;
  assign frame_stall = held_valid && !advance;
  assign take        = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= frame;
    end
  end

  // Area check and shared helpers
  assign usable_h   = (area_height > HEIGHT_MARGIN_AT) ? (area_height - HEIGHT_MARGIN)
                                                       : area_height;
  assign area_ok    = (area_width >= MIN_WIDTH) && (usable_h >= MIN_HEIGHT);
  assign scene_inc  = {1'b0, scene_reg} + 4'd1;
  assign scene_step = (scene_inc >= SceneWrap) ? 3'd0 : scene_inc[2:0];
  assign band_sum   = {2'd0, held.bass_level} + {2'd0, held.mid_level}
                    + {2'd0, held.treble_level};
  assign third_prod = {10'd0, band_sum} * THIRD_RECIP;
  assign energy     = third_prod[18:11];

  // Frame update
  always_comb begin
    logic [7:0]  burst_mid;
    logic [23:0] decay_prod;
    scene_next      = scene_reg;
    age_next        = age_reg;
    beat_next       = beat_reg;
    burst_mid       = burst_reg;
    burst_next      = burst_reg;
    prev_onset_next = prev_onset;
    blank_next      = blank_count;
    phase_next      = phase_regs;
    freeze_next     = freeze_flag;
    blanking_now    = 1'b0;
    beat_now        = 1'b0;
    decay_prod      = 24'd0;
    case (held.cmd)
      CMD_NEXT: begin
        scene_next = scene_step;
        age_next   = 16'd0;
        blank_next = BLANK_FRAMES;
        burst_next = BURST_ON_CHANGE;
      end
      CMD_FREEZE: begin
        freeze_next = !freeze_flag;
      end
      CMD_FRAME: begin
        if (!freeze_flag && area_ok) begin
          // count the rising onset edge, advance the scene every eighth beat or on a strong onset in an old scene
          if (held.onset_level > BEAT_THRESHOLD && prev_onset <= BEAT_THRESHOLD) begin
            beat_now  = 1'b1;
            beat_next = beat_reg + 16'd1;
            if (beat_next[2:0] == 3'd0 ||
                (age_reg > OLD_SCENE_AGE && held.onset_level > STRONG_ONSET)) begin
              scene_next = scene_step;
              age_next   = 16'd0;
              blank_next = BLANK_FRAMES;
              burst_mid  = BURST_ON_CHANGE;
            end
          end
          prev_onset_next = held.onset_level;

          // hold the peak, else decay by 72/100
          decay_prod = {16'd0, burst_mid} * DECAY_RECIP;
          burst_next = (held.onset_level > burst_mid) ? held.onset_level
                                                      : decay_prod[23:16];

          phase_next[0] = phase_regs[0] + 8'd1 + {5'd0, held.treble_level[7:5]};
          phase_next[1] = phase_regs[1] + 8'd2 + {4'd0, held.bass_level[7:4]};
          phase_next[2] = phase_regs[2] + 8'd1 + {5'd0, energy[7:5]};
          phase_next[3] = phase_regs[3] + 8'd2 + {4'd0, held.treble_level[7:4]};
          age_next      = age_next + 16'd1;

          // blank, or drop out of the dark scene
          if (blank_next != 3'd0) begin
            blanking_now = 1'b1;
            blank_next   = blank_next - 3'd1;
          end else if (scene_next >= DARK_DROP_SCENE) begin
            if (age_next > DROP_MIN_AGE && held.onset_level > DROP_ONSET) begin
              scene_next = 3'd0;
              age_next   = 16'd0;
              blank_next = BLANK_FRAMES;
              burst_next = BURST_ON_CHANGE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Commit state on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      scene_reg   <= 3'd0;
      age_reg     <= 16'd0;
      beat_reg    <= 16'd0;
      burst_reg   <= 8'd0;
      prev_onset  <= 8'd0;
      blank_count <= 3'd0;
      phase_regs  <= '{default: 8'd0};
      freeze_flag <= 1'b0;
    end else if (fire) begin
      scene_reg   <= scene_next;
      age_reg     <= age_next;
      beat_reg    <= beat_next;
      burst_reg   <= burst_next;
      prev_onset  <= prev_onset_next;
      blank_count <= blank_next;
      phase_regs  <= phase_next;
      freeze_flag <= freeze_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.scene           <= scene_next;
      result.blanking        <= blanking_now;
      result.blank_left      <= blank_next;
      result.beat_seen       <= beat_now;
      result.beats           <= beat_next;
      result.scene_age       <= age_next;
      result.burst_level     <= burst_next;
      result.hue_phase       <= phase_next[0];
      result.orbit_phase     <= phase_next[1];
      result.drift_phase     <= phase_next[2];
      result.brush_phase_out <= phase_next[3];
      result.is_frozen       <= freeze_next;
    end
  end

  // Checks
  a_scene_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, scene_reg} < SceneWrap)
    else $error("scene out of range");

  a_blank_range: assert property (@(posedge clk) disable iff (rst)
    blank_count <= BLANK_FRAMES)
    else $error("blanking countdown out of range");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(scene_reg) && $stable(beat_reg)
                                     && $stable(age_reg))
    else $error("scene state moved while the result was stalled");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> held_valid && result_valid)
    else $error("frame stalled with room to spare");

endmodule

`default_nettype wire
